// ----- hdl/packet_arrival_statistics_macros.svh -----
// assertion macros used by the packet arrival statistics datapath
`ifndef PACKET_ARRIVAL_STATISTICS_MACROS_SVH
`define PACKET_ARRIVAL_STATISTICS_MACROS_SVH

// same-cycle implication, checked while out of reset
`define PAS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pas same-cycle check failed");

// next-cycle implication, checked while out of reset
`define PAS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pas next-cycle check failed");

`endif

// ----- hdl/pas_pkg.sv -----
// package with constants, types and helpers of the packet arrival statistics block
package pas_pkg;

    localparam int TIME_WIDTH    = 48;
    localparam int COUNT_WIDTH   = 32;
    localparam int FRAC_BITS     = 16;
    localparam int LEN_WIDTH     = 16;
    localparam int SUM_WIDTH     = 64;
    localparam int OUT_WIDTH     = 32;
    localparam int HALF_WIDTH    = 32;
    localparam int NUM_WIDTH     = COUNT_WIDTH + SUM_WIDTH;
    localparam int DIV_WIDTH     = 2 * SUM_WIDTH;
    localparam int ITER_WIDTH    = $clog2(DIV_WIDTH + 1);
    localparam int ROOT_STEPS    = SUM_WIDTH / 2;
    localparam int ROOT_CNT_W    = $clog2(ROOT_STEPS + 1);
    localparam int MUL_STEPS     = 6;
    localparam int MUL_CNT_W     = 3;
    localparam int BITS_WIDTH    = LEN_WIDTH + 3;
    localparam int S_TDATA_WIDTH = 2 * TIME_WIDTH + LEN_WIDTH;
    localparam int M_TDATA_WIDTH = COUNT_WIDTH + 2 * TIME_WIDTH + 2 * OUT_WIDTH;

    typedef enum logic [1:0] {
        DIV_COEF,
        DIV_THR,
        DIV_MDLY,
        DIV_MIA
    } div_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_MUL,
        ST_COEF_GO,
        ST_COEF_WAIT,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_THR_GO,
        ST_THR_WAIT,
        ST_MDLY_GO,
        ST_MDLY_WAIT,
        ST_MIA_GO,
        ST_MIA_WAIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic                 load;
        logic                 square;
        logic                 accum;
        logic                 mul_en;
        logic [MUL_CNT_W-1:0] mul_cnt;
        logic                 div_start;
        div_sel_t             div_sel;
        logic                 sqrt_start;
        logic                 emit;
    } pas_cmd_t;

    typedef struct packed {
        logic div_done;
        logic sqrt_done;
        logic coef_ok;
        logic arr_nz;
        logic out_free;
    } pas_status_t;

    function automatic logic [SUM_WIDTH-1:0] sat_add(input logic [SUM_WIDTH-1:0] a,
                                                     input logic [SUM_WIDTH-1:0] b);
        logic [SUM_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_WIDTH] ? {SUM_WIDTH{1'b1}} : s[SUM_WIDTH-1:0];
    endfunction

endpackage

// ----- hdl/pas_div.sv -----
// restoring divider, one quotient bit per cycle, quotient saturating at 64 bits
module pas_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [pas_pkg::DIV_WIDTH-1:0]    num,
    input  logic [pas_pkg::DIV_WIDTH-1:0]    den,
    input  logic [pas_pkg::ITER_WIDTH-1:0]   iters,
    output logic                             busy,
    output logic                             done,
    output logic [pas_pkg::SUM_WIDTH-1:0]    quot
);
    import pas_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic                  sat_reg, sat_next;
    logic [ITER_WIDTH-1:0] cnt_reg, cnt_next;
    logic [DIV_WIDTH-1:0]  num_reg, num_next;
    logic [DIV_WIDTH-1:0]  den_reg, den_next;
    logic [DIV_WIDTH-1:0]  rem_reg, rem_next;
    logic [SUM_WIDTH-1:0]  q_reg, q_next;
    logic [DIV_WIDTH:0]    rem_sh;
    logic [DIV_WIDTH:0]    diff;
    logic                  ge;

    assign rem_sh = {rem_reg, num_reg[DIV_WIDTH-1]};
    assign diff   = rem_sh - {1'b0, den_reg};
    assign ge     = rem_sh >= {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        sat_next  = sat_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        if (start) begin
            busy_next = 1'b1;
            sat_next  = 1'b0;
            cnt_next  = iters;
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
            q_next    = '0;
        end else if (busy_reg) begin
            num_next = num_reg << 1;
            rem_next = ge ? diff[DIV_WIDTH-1:0] : rem_sh[DIV_WIDTH-1:0];
            q_next   = {q_reg[SUM_WIDTH-2:0], ge};
            // a set bit above the 64-bit range means overflow
            if (ge && (cnt_reg > ITER_WIDTH'(SUM_WIDTH))) begin
                sat_next = 1'b1;
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == ITER_WIDTH'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        sat_reg <= sat_next;
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = sat_reg ? {SUM_WIDTH{1'b1}} : q_reg;

endmodule

// ----- hdl/pas_sqrt.sv -----
// integer square root of a 64-bit value, two radicand bits per cycle
module pas_sqrt (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [pas_pkg::SUM_WIDTH-1:0]  x,
    output logic                           busy,
    output logic                           done,
    output logic [pas_pkg::OUT_WIDTH-1:0]  root
);
    import pas_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [ROOT_CNT_W-1:0] cnt_reg, cnt_next;
    logic [SUM_WIDTH-1:0]  x_reg, x_next;
    logic [SUM_WIDTH-1:0]  res_reg, res_next;
    logic [SUM_WIDTH-1:0]  bit_reg, bit_next;
    logic [SUM_WIDTH-1:0]  trial;

    assign trial = res_reg + bit_reg;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = ROOT_CNT_W'(ROOT_STEPS);
            x_next    = x;
            res_next  = '0;
            bit_next  = SUM_WIDTH'(1) << (SUM_WIDTH - 2);
        end else if (busy_reg) begin
            if (x_reg >= trial) begin
                x_next   = x_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == ROOT_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        x_reg   <= x_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign root = res_reg[OUT_WIDTH-1:0];

endmodule

// ----- hdl/pas_datapath.sv -----
// datapath: running sums, shared 32x32 multiplier, divider, square root, output register
module pas_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  pas_pkg::pas_cmd_t                 cmd,
    output pas_pkg::pas_status_t              status,
    input  logic [pas_pkg::TIME_WIDTH-1:0]    arrival_time,
    input  logic [pas_pkg::TIME_WIDTH-1:0]    creation_time,
    input  logic [pas_pkg::LEN_WIDTH-1:0]     length_bytes,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pas_pkg::M_TDATA_WIDTH-1:0] m_tdata,
    output logic                              m_tuser
);
    import pas_pkg::*;
    `include "packet_arrival_statistics_macros.svh"

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [TIME_WIDTH-1:0]  TIME_MAX  = {TIME_WIDTH{1'b1}};

    logic [COUNT_WIDTH-1:0]   count_reg;
    logic [SUM_WIDTH-1:0]     delay_sum_reg, ia_sum_reg, sq_sum_reg, bit_sum_reg;
    logic [TIME_WIDTH-1:0]    last_arrival_reg;
    logic [TIME_WIDTH-1:0]    arr_reg, delay_reg, ia_reg;
    logic [BITS_WIDTH-1:0]    bits_reg;
    logic [SUM_WIDTH-1:0]     sq_reg;
    logic [SUM_WIDTH-1:0]     pp_reg;
    logic [NUM_WIDTH-1:0]     num_reg;
    logic [DIV_WIDTH-1:0]     den_reg;
    logic [OUT_WIDTH-1:0]     coeff_reg, thr_reg;
    logic [TIME_WIDTH-1:0]    mdelay_reg, mia_reg;
    logic                     m_tvalid_reg;
    logic [M_TDATA_WIDTH-1:0] m_tdata_reg;
    logic                     m_tuser_reg;

    logic [HALF_WIDTH-1:0]    a_op, b_op;
    logic [MUL_CNT_W-1:0]     add_step;
    logic [DIV_WIDTH-1:0]     coef_diff;
    logic [DIV_WIDTH-1:0]     div_num, div_den;
    logic [ITER_WIDTH-1:0]    div_iters;
    logic [SUM_WIDTH-1:0]     quot;
    logic                     div_busy, div_done;
    logic [OUT_WIDTH-1:0]     root;
    logic                     sqrt_busy, sqrt_done;
    logic                     out_free;

    // multiplier operand selection per partial-product step
    always_comb begin
        a_op = '0;
        b_op = '0;
        case (cmd.mul_cnt)
            3'd0: begin a_op = count_reg; b_op = sq_sum_reg[HALF_WIDTH-1:0]; end
            3'd1: begin a_op = count_reg; b_op = sq_sum_reg[SUM_WIDTH-1:HALF_WIDTH]; end
            3'd2: begin
                a_op = ia_sum_reg[HALF_WIDTH-1:0];
                b_op = ia_sum_reg[HALF_WIDTH-1:0];
            end
            3'd3: begin
                a_op = ia_sum_reg[HALF_WIDTH-1:0];
                b_op = ia_sum_reg[SUM_WIDTH-1:HALF_WIDTH];
            end
            3'd4: begin
                a_op = ia_sum_reg[SUM_WIDTH-1:HALF_WIDTH];
                b_op = ia_sum_reg[HALF_WIDTH-1:0];
            end
            3'd5: begin
                a_op = ia_sum_reg[SUM_WIDTH-1:HALF_WIDTH];
                b_op = ia_sum_reg[SUM_WIDTH-1:HALF_WIDTH];
            end
            default: begin a_op = '0; b_op = '0; end
        endcase
    end

    assign add_step  = cmd.mul_cnt - 1'b1;
    assign coef_diff = {{(DIV_WIDTH-NUM_WIDTH){1'b0}}, num_reg} - den_reg;

    // divider operands: numerators are aligned to the top of the shift register
    always_comb begin
        div_num   = '0;
        div_den   = '0;
        div_iters = '0;
        case (cmd.div_sel)
            DIV_COEF: begin
                div_num   = coef_diff << (2 * FRAC_BITS);
                div_den   = den_reg;
                div_iters = ITER_WIDTH'(DIV_WIDTH);
            end
            DIV_THR: begin
                div_num   = {bit_sum_reg, {SUM_WIDTH{1'b0}}};
                div_den   = DIV_WIDTH'(arr_reg);
                div_iters = ITER_WIDTH'(SUM_WIDTH + FRAC_BITS);
            end
            DIV_MDLY: begin
                div_num   = {delay_sum_reg, {SUM_WIDTH{1'b0}}};
                div_den   = DIV_WIDTH'(count_reg);
                div_iters = ITER_WIDTH'(SUM_WIDTH);
            end
            DIV_MIA: begin
                div_num   = {ia_sum_reg, {SUM_WIDTH{1'b0}}};
                div_den   = DIV_WIDTH'(count_reg);
                div_iters = ITER_WIDTH'(SUM_WIDTH);
            end
            default: begin
                div_num   = '0;
                div_den   = '0;
                div_iters = '0;
            end
        endcase
    end

    pas_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .iters   (div_iters),
        .busy    (div_busy),
        .done    (div_done),
        .quot    (quot)
    );

    pas_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.sqrt_start),
        .x       (quot),
        .busy    (sqrt_busy),
        .done    (sqrt_done),
        .root    (root)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg        <= '0;
            delay_sum_reg    <= '0;
            ia_sum_reg       <= '0;
            sq_sum_reg       <= '0;
            bit_sum_reg      <= '0;
            last_arrival_reg <= '0;
        end else begin
            if (cmd.load) begin
                if (count_reg != COUNT_MAX) begin
                    count_reg <= count_reg + 1'b1;
                end
                last_arrival_reg <= arrival_time;
            end
            if (cmd.accum) begin
                delay_sum_reg <= sat_add(delay_sum_reg, SUM_WIDTH'(delay_reg));
                ia_sum_reg    <= sat_add(ia_sum_reg, SUM_WIDTH'(ia_reg));
                sq_sum_reg    <= sat_add(sq_sum_reg, sq_reg);
                bit_sum_reg   <= sat_add(bit_sum_reg, SUM_WIDTH'(bits_reg));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            arr_reg   <= arrival_time;
            delay_reg <= (arrival_time >= creation_time) ? arrival_time - creation_time : '0;
            ia_reg    <= (arrival_time >= last_arrival_reg) ?
                         arrival_time - last_arrival_reg : '0;
            bits_reg  <= {length_bytes, 3'b000};
        end
        if (cmd.square) begin
            sq_reg <= (ia_reg[TIME_WIDTH-1:HALF_WIDTH] != '0) ? {SUM_WIDTH{1'b1}} :
                      SUM_WIDTH'(ia_reg[HALF_WIDTH-1:0]) * SUM_WIDTH'(ia_reg[HALF_WIDTH-1:0]);
        end
        if (cmd.accum) begin
            num_reg   <= '0;
            den_reg   <= '0;
            coeff_reg <= '0;
            thr_reg   <= '0;
        end
        if (cmd.mul_en) begin
            if (cmd.mul_cnt < MUL_CNT_W'(MUL_STEPS)) begin
                pp_reg <= SUM_WIDTH'(a_op) * SUM_WIDTH'(b_op);
            end
            if (cmd.mul_cnt != '0) begin
                case (add_step)
                    3'd0:    num_reg <= num_reg + NUM_WIDTH'(pp_reg);
                    3'd1:    num_reg <= num_reg + (NUM_WIDTH'(pp_reg) << HALF_WIDTH);
                    3'd2:    den_reg <= den_reg + DIV_WIDTH'(pp_reg);
                    3'd3,
                    3'd4:    den_reg <= den_reg + (DIV_WIDTH'(pp_reg) << HALF_WIDTH);
                    3'd5:    den_reg <= den_reg + (DIV_WIDTH'(pp_reg) << SUM_WIDTH);
                    default: den_reg <= den_reg;
                endcase
            end
        end
        if (sqrt_done) begin
            coeff_reg <= root;
        end
        if (div_done) begin
            case (cmd.div_sel)
                DIV_THR: thr_reg <= (quot[SUM_WIDTH-1:OUT_WIDTH] != '0) ?
                                    {OUT_WIDTH{1'b1}} : quot[OUT_WIDTH-1:0];
                DIV_MDLY: mdelay_reg <= (quot > SUM_WIDTH'(TIME_MAX)) ?
                                        TIME_MAX : quot[TIME_WIDTH-1:0];
                DIV_MIA: mia_reg <= (quot > SUM_WIDTH'(TIME_MAX)) ?
                                    TIME_MAX : quot[TIME_WIDTH-1:0];
                default: thr_reg <= thr_reg;
            endcase
        end
    end

    // output register frees the datapath while a result waits
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (cmd.emit) begin
            m_tdata_reg <= {thr_reg, coeff_reg, mia_reg, mdelay_reg, count_reg};
            m_tuser_reg <= (ia_sum_reg == '0) || (arr_reg == '0);
        end
    end

    assign status.div_done  = div_done;
    assign status.sqrt_done = sqrt_done;
    assign status.coef_ok   = (ia_sum_reg != '0) &&
                              ({{(DIV_WIDTH-NUM_WIDTH){1'b0}}, num_reg} > den_reg);
    assign status.arr_nz    = arr_reg != '0;
    assign status.out_free  = out_free;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `PAS_ASSERT_IMP(a_div_start_idle, cmd.div_start, !div_busy)
    `PAS_ASSERT_IMP(a_sqrt_start_idle, cmd.sqrt_start, !sqrt_busy && !div_busy)
    `PAS_ASSERT_NEXT(a_emit_shows_count, cmd.emit, m_tvalid_reg && (count_reg != '0))

endmodule

// ----- hdl/pas_ctrl.sv -----
// controller: sequences update, multiply, divisions and square root for one packet
module pas_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  pas_pkg::pas_status_t status,
    output pas_pkg::pas_cmd_t    cmd
);
    import pas_pkg::*;

    state_t               state_reg, state_next;
    logic [MUL_CNT_W-1:0] mul_cnt_reg, mul_cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mul_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            mul_cnt_reg <= mul_cnt_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        mul_cnt_next   = mul_cnt_reg;
        s_tready       = 1'b0;
        cmd            = '0;
        cmd.mul_cnt    = mul_cnt_reg;
        cmd.div_sel    = DIV_COEF;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                cmd.square = 1'b1;
                state_next = ST_ACCUM;
            end
            ST_ACCUM: begin
                cmd.accum    = 1'b1;
                mul_cnt_next = '0;
                state_next   = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul_en   = 1'b1;
                mul_cnt_next = mul_cnt_reg + 1'b1;
                if (mul_cnt_reg == MUL_CNT_W'(MUL_STEPS)) begin
                    state_next = ST_COEF_GO;
                end
            end
            ST_COEF_GO: begin
                cmd.div_sel = DIV_COEF;
                if (status.coef_ok) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_COEF_WAIT;
                end else begin
                    state_next = ST_THR_GO;
                end
            end
            ST_COEF_WAIT: begin
                cmd.div_sel = DIV_COEF;
                if (status.div_done) begin
                    state_next = ST_SQRT_GO;
                end
            end
            ST_SQRT_GO: begin
                cmd.sqrt_start = 1'b1;
                state_next     = ST_SQRT_WAIT;
            end
            ST_SQRT_WAIT: begin
                if (status.sqrt_done) begin
                    state_next = ST_THR_GO;
                end
            end
            ST_THR_GO: begin
                cmd.div_sel = DIV_THR;
                if (status.arr_nz) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_THR_WAIT;
                end else begin
                    state_next = ST_MDLY_GO;
                end
            end
            ST_THR_WAIT: begin
                cmd.div_sel = DIV_THR;
                if (status.div_done) begin
                    state_next = ST_MDLY_GO;
                end
            end
            ST_MDLY_GO: begin
                cmd.div_sel   = DIV_MDLY;
                cmd.div_start = 1'b1;
                state_next    = ST_MDLY_WAIT;
            end
            ST_MDLY_WAIT: begin
                cmd.div_sel = DIV_MDLY;
                if (status.div_done) begin
                    state_next = ST_MIA_GO;
                end
            end
            ST_MIA_GO: begin
                cmd.div_sel   = DIV_MIA;
                cmd.div_start = 1'b1;
                state_next    = ST_MIA_WAIT;
            end
            ST_MIA_WAIT: begin
                cmd.div_sel = DIV_MIA;
                if (status.div_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/packet_arrival_statistics.sv -----
// top level of the packet arrival statistics block
//
// usage:
// - input words on s_axis: arrival time, creation time and length of one packet,
//   accepted when s_tvalid and s_tready are both high
// - one result word per input word on m_axis: packet count, mean delay,
//   mean interarrival, interarrival coefficient of variation (q16.16),
//   throughput in bits per tick (q16.16); m_tuser flags a zero interarrival
//   sum or a zero arrival time
// - one packet at a time: s_tready is high only while the sequencer is idle
// - the time from accept to m_tvalid is set by the shared serial divider
//   (128 + 80 + 64 + 64 iterations) and the 32-step square root; it is shorter
//   when the coefficient or throughput division is skipped
// - the next packet is accepted only once the result is in the output register
// - the result sits in an output register, so a stalled receiver does not hold
//   back the next packet's computation; only the final load waits for m_tready
// - reset (aresetn low, synchronous) clears the count, all sums and the last
//   arrival time, and drops m_tvalid
module packet_arrival_statistics (
    input  logic                              aclk,
    input  logic                              aresetn,
    // slave side
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // arrival_time[47:0], creation_time[95:48], length_bytes[111:96]
    input  logic [pas_pkg::S_TDATA_WIDTH-1:0] s_tdata,
    // master side
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // packet_count[31:0], mean_delay[79:32], mean_interarrival[127:80],
    // variation_coeff[159:128], throughput[191:160]
    output logic [pas_pkg::M_TDATA_WIDTH-1:0] m_tdata,
    // set when the interarrival sum or the arrival time is zero
    output logic                              m_tuser
);
    import pas_pkg::*;

    pas_cmd_t    cmd;
    pas_status_t status;

    // unpack the input word
    logic [TIME_WIDTH-1:0] arrival_time;
    logic [TIME_WIDTH-1:0] creation_time;
    logic [LEN_WIDTH-1:0]  length_bytes;

    assign arrival_time  = s_tdata[TIME_WIDTH-1:0];
    assign creation_time = s_tdata[2*TIME_WIDTH-1:TIME_WIDTH];
    assign length_bytes  = s_tdata[S_TDATA_WIDTH-1:2*TIME_WIDTH];

    // sequencer
    pas_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // sums, arithmetic units and the output register
    pas_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .arrival_time  (arrival_time),
        .creation_time (creation_time),
        .length_bytes  (length_bytes),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser)
    );

endmodule
